FILE: src/rtcb_pkg.sv
// shared types, codes and byte conversions for the three-wire rtc burst master
`default_nettype none
package rtcb_pkg;

  // request codes on the operation field
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  // status codes of each result beat
  typedef enum logic [1:0] {
    STATUS_IDLE = 2'd0,
    STATUS_BUSY = 2'd1,
    STATUS_DONE = 2'd2,
    STATUS_RSVD = 2'd3
  } status_e;

  // bytes sent on the wire
  localparam logic [7:0] CMD_BURST_WR = 8'hBE;
  localparam logic [7:0] CMD_BURST_RD = 8'hBF;
  localparam logic [7:0] CMD_CONTROL  = 8'h8E;
  localparam logic [7:0] WP_ON        = 8'h80;
  localparam logic [7:0] WP_OFF       = 8'h00;

  localparam int unsigned NumRegs = 7;

  // one result beat
  typedef struct packed {
    logic                        chip_enable;
    logic                        serial_clock;
    logic                        data_out;
    logic                        data_drive;
    status_e                     status;
    logic [NumRegs-1:0][7:0]     got;
  } result_t;

  // binary to bcd with clamp at 99; tens digit by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [6:0]  b;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    b    = (v > 7'd99) ? 7'd99 : v;
    prod = 15'(b) * 15'd205;
    tens = prod[14:11];
    ones = b - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
    return {tens, ones[3:0]};
  endfunction

  // bcd to binary: high nibble times ten plus low nibble
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
  endfunction

endpackage
`default_nettype wire

FILE: src/rtcb_seq.sv
// bit sequencer: holds transfer state and forms one result per tick
`default_nettype none
module rtcb_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [1:0]                    operation_i,
  input  wire logic                          sda_in_i,
  input  wire logic [rtcb_pkg::NumRegs-1:0][6:0] set_value_i,
  output rtcb_pkg::result_t                  result_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_BIT,
    ST_FINISH
  } step_e;

  step_e       step_q, step_d;
  logic        kind_q, kind_d;
  logic [3:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic        half_q, half_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  pending_q [rtcb_pkg::NumRegs];
  logic [7:0]  pending_d [rtcb_pkg::NumRegs];
  logic [rtcb_pkg::NumRegs-1:0][7:0] captured_q, captured_d;

  logic        reading;
  logic        sck;
  logic [7:0]  tx_byte;
  logic [2:0]  pend_idx;
  logic [2:0]  cap_idx;

  // byte to send for the current byte slot
  always_comb begin
    pend_idx = 3'(byte_q - 4'd3);
    tx_byte  = rtcb_pkg::WP_ON;
    if (!kind_q) begin
      tx_byte = rtcb_pkg::CMD_BURST_RD;
    end else if (byte_q == 4'd0) begin
      tx_byte = rtcb_pkg::CMD_CONTROL;
    end else if (byte_q == 4'd1) begin
      tx_byte = rtcb_pkg::WP_OFF;
    end else if (byte_q == 4'd2) begin
      tx_byte = rtcb_pkg::CMD_BURST_WR;
    end else if (byte_q >= 4'd3 && byte_q <= 4'd9) begin
      tx_byte = pending_q[pend_idx];
    end
  end

  // next state and pin levels of this tick
  always_comb begin
    step_d     = step_q;
    kind_d     = kind_q;
    byte_d     = byte_q;
    bit_d      = bit_q;
    half_d     = half_q;
    shift_d    = shift_q;
    pending_d  = pending_q;
    captured_d = captured_q;
    reading    = !kind_q && (byte_q != 4'd0);
    sck        = 1'b0;
    cap_idx    = 3'(byte_q - 4'd1);

    result_o.chip_enable  = 1'b0;
    result_o.serial_clock = 1'b0;
    result_o.data_out     = 1'b0;
    result_o.data_drive   = 1'b1;
    result_o.status       = rtcb_pkg::STATUS_BUSY;

    case (step_q)
      ST_IDLE: begin
        if (operation_i == rtcb_pkg::OP_READ || operation_i == rtcb_pkg::OP_WRITE) begin
          kind_d = (operation_i == rtcb_pkg::OP_WRITE);
          if (kind_d) begin
            for (int i = 0; i < rtcb_pkg::NumRegs; i++) begin
              pending_d[i] = rtcb_pkg::to_bcd(set_value_i[i]);
            end
          end
          byte_d = 4'd0;
          bit_d  = 3'd0;
          half_d = 1'b0;
          step_d = ST_BIT;
        end else begin
          result_o.status = rtcb_pkg::STATUS_IDLE;
        end
      end
      ST_START: begin
        bit_d  = 3'd0;
        half_d = 1'b0;
        step_d = ST_BIT;
      end
      ST_BIT: begin
        result_o.chip_enable = 1'b1;
        if (!half_q) begin
          if (reading) begin
            shift_d = {sda_in_i, shift_q[7:1]};
          end else if (bit_q == 3'd0) begin
            shift_d = tx_byte;
          end
          half_d = 1'b1;
        end else begin
          sck    = 1'b1;
          half_d = 1'b0;
        end
        result_o.serial_clock = sck;
        if (reading) begin
          result_o.data_drive = 1'b0;
        end else begin
          result_o.data_out = shift_d[bit_q];
        end
        // end of a bit: advance, capture and close bytes
        if (sck) begin
          if (bit_q != 3'd7) begin
            bit_d = bit_q + 3'd1;
          end else begin
            bit_d = 3'd0;
            if (reading && byte_q <= 4'd7) begin
              captured_d[cap_idx] = rtcb_pkg::from_bcd(shift_d);
            end
            byte_d = byte_q + 4'd1;
            if (!kind_q) begin
              if (byte_d >= 4'd9) step_d = ST_FINISH;
            end else begin
              if (byte_d == 4'd2) begin
                step_d = ST_START;
              end else if (byte_d >= 4'd11) begin
                step_d = ST_FINISH;
              end
            end
          end
        end
      end
      default: begin
        result_o.status = rtcb_pkg::STATUS_DONE;
        step_d          = ST_IDLE;
      end
    endcase

    result_o.got = captured_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= ST_IDLE;
      kind_q     <= 1'b0;
      byte_q     <= 4'd0;
      bit_q      <= 3'd0;
      half_q     <= 1'b0;
      shift_q    <= 8'd0;
      captured_q <= '0;
    end else if (accept_i) begin
      step_q     <= step_d;
      kind_q     <= kind_d;
      byte_q     <= byte_d;
      bit_q      <= bit_d;
      half_q     <= half_d;
      shift_q    <= shift_d;
      captured_q <= captured_d;
    end
  end

  // latched write values, no reset
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pending_q <= pending_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/rtc_three_wire_burst_master_top.sv
// top level: tick channel, sequencer and result register
// Three-wire real-time-clock burst master. Each input beat is one half bit
// period of the serial bus; each beat gives exactly one result beat with the
// pin levels (enable, clock, data, drive), a status code and the seven
// converted time bytes of the last read.
// Input channel: in_valid_i / in_stall_o with operation, sampled data pin
// and the seven binary write values. Output channel: out_valid_o /
// out_stall_i with the pin levels, status and got_* bytes.
// An accepted beat's result is in the output register in the next cycle.
// Throughput: one beat per cycle unless the receiver stalls; the sequencer
// works out a tick in a single pass, stored straight in the result register.
// A burst read takes 146 ticks and a burst write 179, counting the request
// tick, the enable gap of a write and the finish tick.
// When the receiver stalls, the held result stays put and in_stall_o is
// raised so the sequencer does not advance.
// Reset clears the sequencer to idle and the captured bytes to zero; the
// output register comes up empty.
`default_nettype none
module rtc_three_wire_burst_master_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] operation_i,
  input  wire logic       sda_in_i,
  input  wire logic [6:0] set_second_i,
  input  wire logic [6:0] set_minute_i,
  input  wire logic [6:0] set_hour_i,
  input  wire logic [6:0] set_date_i,
  input  wire logic [6:0] set_month_i,
  input  wire logic [6:0] set_weekday_i,
  input  wire logic [6:0] set_year_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            chip_enable_o,
  output logic            serial_clock_o,
  output logic            data_out_o,
  output logic            data_drive_o,
  output logic [1:0]      status_o,
  output logic [7:0]      got_second_o,
  output logic [7:0]      got_minute_o,
  output logic [7:0]      got_hour_o,
  output logic [7:0]      got_date_o,
  output logic [7:0]      got_month_o,
  output logic [7:0]      got_weekday_o,
  output logic [7:0]      got_year_o
);

  logic                                   accept;
  logic                                   out_valid_q, out_valid_d;
  logic [rtcb_pkg::NumRegs-1:0][6:0]      set_value;
  rtcb_pkg::result_t                      result;
  rtcb_pkg::result_t                      result_q;

  // handshake: take a beat whenever the result register is free or drains
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  // write values in register order
  assign set_value = {set_year_i, set_weekday_i, set_month_i, set_date_i,
                      set_hour_i, set_minute_i, set_second_i};

  rtcb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .sda_in_i    (sda_in_i),
    .set_value_i (set_value),
    .result_o    (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  // output fields
  assign out_valid_o    = out_valid_q;
  assign chip_enable_o  = result_q.chip_enable;
  assign serial_clock_o = result_q.serial_clock;
  assign data_out_o     = result_q.data_out;
  assign data_drive_o   = result_q.data_drive;
  assign status_o       = result_q.status;
  assign got_second_o   = result_q.got[0];
  assign got_minute_o   = result_q.got[1];
  assign got_hour_o     = result_q.got[2];
  assign got_date_o     = result_q.got[3];
  assign got_month_o    = result_q.got[4];
  assign got_weekday_o  = result_q.got[5];
  assign got_year_o     = result_q.got[6];

  // checks
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat gave no result");

  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != rtcb_pkg::STATUS_BUSY) |-> (!chip_enable_o && !serial_clock_o
      && data_drive_o && !data_out_o))
    else $error("pins not at idle levels outside a transfer");

  a_release_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !data_drive_o) |-> (chip_enable_o && !data_out_o))
    else $error("data released outside an enabled read");

  // the last accepted tick stays in result_q even after it has drained
  a_clock_low_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && result.serial_clock) |-> result_q.chip_enable)
    else $error("clock high without a preceding enabled tick");

endmodule
`default_nettype wire
